[hdl/tis_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timestamp insertion sorter package
// Shared types and constants for the sorter chain, its cells and control.
// ---------------------------------------------------------------------------
package tis_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int TAG_W    = 6;

  // Field order sets the sort order: year is most significant.
  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } key_t;

  typedef logic [TAG_W-1:0] tag_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  // Commands from the control block to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert the broadcast record
    logic shift;  // move every entry one cell toward the head
  } ctrl_t;

endpackage

[hdl/tis_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorter cell
// Holds one table entry. On insert it keeps its entry, takes the left
// neighbor's entry or takes the new record; on drain it takes the right one.
// ---------------------------------------------------------------------------
module tis_cell (
  input  logic           clk,
  input  tis_pkg::ctrl_t ctrl,
  input  logic           occ,
  input  tis_pkg::key_t  new_key,
  input  tis_pkg::tag_t  new_tag,
  input  logic           prev_ahead,
  input  tis_pkg::key_t  prev_key,
  input  tis_pkg::tag_t  prev_tag,
  input  tis_pkg::key_t  next_key,
  input  tis_pkg::tag_t  next_tag,
  output logic           ahead,
  output tis_pkg::key_t  key,
  output tis_pkg::tag_t  tag
);

  tis_pkg::key_t key_r, key_nxt;
  tis_pkg::tag_t tag_r, tag_nxt;

  // The new record goes ahead of this entry when this entry is strictly later
  // or the cell is empty; equal keys stay put, which keeps the sort stable.
  assign ahead = !occ || (new_key < key_r);

  always_comb begin
    key_nxt = key_r;
    tag_nxt = tag_r;
    if (ctrl.ins && ahead) begin
      if (prev_ahead) begin
        key_nxt = prev_key;
        tag_nxt = prev_tag;
      end else begin
        key_nxt = new_key;
        tag_nxt = new_tag;
      end
    end else if (ctrl.shift) begin
      key_nxt = next_key;
      tag_nxt = next_tag;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  assign key = key_r;
  assign tag = tag_r;

endmodule

[hdl/tis_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorter control
// Tracks the fill count and overflow flag, and sequences fill and drain.
// ---------------------------------------------------------------------------
module tis_ctrl #(
  parameter int DEPTH = 64,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last_record,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_last_out,
  output logic             overflow,
  output logic [CNT_W-1:0] fill,
  output tis_pkg::tag_t    new_tag,
  output tis_pkg::ctrl_t   ctrl
);

  tis_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             ovf_r, ovf_nxt;
  logic             in_xfer, out_xfer, full, run_done;
  logic [CNT_W+tis_pkg::TAG_W-1:0] fill_ext;

  assign full     = (fill_r == CNT_W'(DEPTH));
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  // In drain the fill count is the number of entries still to send.
  assign run_done = out_xfer && (fill_r == CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tis_pkg::ST_FILL:  if (in_xfer && in_last_record) state_nxt = tis_pkg::ST_DRAIN;
      tis_pkg::ST_DRAIN: if (run_done) state_nxt = tis_pkg::ST_FILL;
      default:           state_nxt = tis_pkg::ST_FILL;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      tis_pkg::ST_FILL:  in_ready  = 1'b1;
      tis_pkg::ST_DRAIN: out_valid = 1'b1;
      default:           in_ready  = 1'b0;
    endcase
  end

  always_comb begin
    ctrl.ins   = in_xfer && !full;
    ctrl.shift = out_xfer;
    fill_nxt   = fill_r;
    ovf_nxt    = ovf_r;
    if (ctrl.ins)   fill_nxt = fill_r + CNT_W'(1);
    if (ctrl.shift) fill_nxt = fill_r - CNT_W'(1);
    if (in_xfer && full) ovf_nxt = 1'b1;
    if (run_done)        ovf_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tis_pkg::ST_FILL;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // The arrival index is the fill count at acceptance, wrapped to the tag width.
  assign fill_ext     = {{tis_pkg::TAG_W{1'b0}}, fill_r};
  assign new_tag      = fill_ext[tis_pkg::TAG_W-1:0];
  assign fill         = fill_r;
  assign overflow     = ovf_r;
  assign out_last_out = (fill_r == CNT_W'(1));

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill count above table depth");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tis_pkg::ST_DRAIN) |-> (fill_r != '0))
    else $error("draining an empty table");

  a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_last_record) |=> out_valid)
    else $error("last record did not start a run");

  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    run_done |=> (fill_r == '0) && !ovf_r && in_ready)
    else $error("state not cleared after run");

  a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && full) |=> ovf_r)
    else $error("dropped record not flagged");

endmodule

[hdl/timestamp_insertion_sorter_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timestamp insertion sorter
// Stable insertion sort of timestamp records in a chain of cells, emitted
// in order with arrival indices when a record marked last arrives.
// ---------------------------------------------------------------------------
//  Channel | Ports                               | Direction
//  --------+-------------------------------------+----------
//  input   | in_valid/in_ready, in_year..last    | into block
//  result  | out_valid/out_ready, out_year..last | out of block
//
// Each record is inserted as it is accepted: it is broadcast to every
// cell, which compares and shifts in parallel, so records may arrive back to
// back. After the last record, a run of n entries drains at one transfer per
// cycle from the head cell while in_ready is low; the first result is valid
// the cycle after the last record. A stalled result simply holds the chain.
// Reset clears the fill count, overflow flag and state; table contents are not
// cleared and no clearing pass is needed.
// ---------------------------------------------------------------------------
module timestamp_insertion_sorter_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  logic        in_last_record,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [5:0]  out_arrival_index,
  output logic        out_overflowed,
  output logic        out_last_out
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  tis_pkg::ctrl_t   ctrl;
  tis_pkg::key_t    new_key;
  tis_pkg::tag_t    new_tag;
  logic [CNT_W-1:0] fill;
  logic             overflow;

  tis_pkg::key_t          cell_key [TABLE_DEPTH];
  tis_pkg::tag_t          cell_tag [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ahead;
  logic [TABLE_DEPTH-1:0] occ;

  assign new_key = '{year: in_year, month: in_month, day: in_day,
                     hour: in_hour, minute: in_minute, second: in_second};

  tis_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_record (in_last_record),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_last_out   (out_last_out),
    .overflow       (overflow),
    .fill           (fill),
    .new_tag        (new_tag),
    .ctrl           (ctrl)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    // Entries below the fill count are live; the rest hold stale data.
    assign occ[i] = (CNT_W'(i) < fill);

    if (i == 0) begin : g_head
      tis_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occ        (occ[i]),
        .new_key    (new_key),
        .new_tag    (new_tag),
        .prev_ahead (1'b0),
        .prev_key   (new_key),
        .prev_tag   (new_tag),
        .next_key   (cell_key[(i+1) % TABLE_DEPTH]),
        .next_tag   (cell_tag[(i+1) % TABLE_DEPTH]),
        .ahead      (ahead[i]),
        .key        (cell_key[i]),
        .tag        (cell_tag[i])
      );
    end else if (i == TABLE_DEPTH - 1) begin : g_tail
      tis_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occ        (occ[i]),
        .new_key    (new_key),
        .new_tag    (new_tag),
        .prev_ahead (ahead[i-1]),
        .prev_key   (cell_key[i-1]),
        .prev_tag   (cell_tag[i-1]),
        .next_key   (cell_key[i]),
        .next_tag   (cell_tag[i]),
        .ahead      (ahead[i]),
        .key        (cell_key[i]),
        .tag        (cell_tag[i])
      );
    end else begin : g_mid
      tis_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occ        (occ[i]),
        .new_key    (new_key),
        .new_tag    (new_tag),
        .prev_ahead (ahead[i-1]),
        .prev_key   (cell_key[i-1]),
        .prev_tag   (cell_tag[i-1]),
        .next_key   (cell_key[i+1]),
        .next_tag   (cell_tag[i+1]),
        .ahead      (ahead[i]),
        .key        (cell_key[i]),
        .tag        (cell_tag[i])
      );
    end
  end

  assign out_year          = cell_key[0].year;
  assign out_month         = cell_key[0].month;
  assign out_day           = cell_key[0].day;
  assign out_hour          = cell_key[0].hour;
  assign out_minute        = cell_key[0].minute;
  assign out_second        = cell_key[0].second;
  assign out_arrival_index = cell_tag[0];
  assign out_overflowed    = overflow;

endmodule
